[design/uer_pkg.sv]
// Shared constants for the ultrasonic echo ranger: phase and status codes,
// trigger timing, reset values of the configuration registers.
// No dependencies.
package uer_pkg;

	// Default widths of the microsecond counter and the prescaler.
	localparam int unsigned UER_US_COUNT_WIDTH = 16;
	localparam int unsigned UER_PRESCALE_WIDTH = 8;

	// Configuration port geometry.
	localparam int unsigned CFG_DATA_WIDTH  = 16;
	localparam int unsigned CFG_INDEX_WIDTH = 3;

	// Register indexes.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_PER_US = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TO     = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_TO       = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_DIST     = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_DIST     = 3'd4;

	// Register reset values.
	localparam logic [7:0]  RST_TICKS_PER_US = 8'd1;
	localparam logic [15:0] RST_START_TO     = 16'd15000;
	localparam logic [15:0] RST_END_TO       = 16'd25000;
	localparam logic [8:0]  RST_MIN_DIST     = 9'd2;
	localparam logic [8:0]  RST_MAX_DIST     = 9'd350;

	// Trigger pulse timing in microseconds.
	localparam int unsigned TRIG_LOW_US  = 2;
	localparam int unsigned TRIG_HIGH_US = 10;

	// Phase codes.
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_TLOW  = 3'd1;
	localparam logic [2:0] PH_THIGH = 3'd2;
	localparam logic [2:0] PH_WAIT  = 3'd3;
	localparam logic [2:0] PH_MEAS  = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOECHO = 2'd1;
	localparam logic [1:0] ST_LONG   = 2'd2;
	localparam logic [1:0] ST_RANGE  = 2'd3;

	// Distance conversion: q = floor(us * 8 / 29) = (us * DIST_RECIP) >> DIST_SHIFT,
	// exact for us below 2^15. Larger durations are clamped, they fail range anyway.
	localparam int unsigned DIST_CLAMP_WIDTH = 15;
	localparam int unsigned DIST_RECIP_WIDTH = 20;
	localparam logic [DIST_RECIP_WIDTH-1:0] DIST_RECIP = 20'd578525;
	localparam int unsigned DIST_SHIFT = 21;
	localparam int unsigned DIST_Q_WIDTH = 14;
	localparam int unsigned DIST_WIDTH = 13;

	// One result word.
	typedef struct packed {
		logic                  trig_level;
		logic                  busy_res;
		logic                  done_res;
		logic [1:0]            status;
		logic [DIST_WIDTH-1:0] distance_q4;
	} res_t;

endpackage

[design/ultrasonic_echo_ranger.sv]
// Ultrasonic ranging controller: trigger pulse generation, echo timing,
// distance conversion and range check. Depends on uer_pkg.
//
// Usage: every input word is one tick carrying start_req and the sampled
// echo_level, taken on in_valid && in_ready. Every accepted word yields exactly
// one result word (trig_level, busy_res, done_res, status, distance_q4) that
// reflects the state after that tick, offered on out_valid / out_ready.
// A start request in idle runs: trigger low for 2 us, high for 10 us, then
// waits for the echo to rise (start timeout) and times the echo high pulse
// (end timeout). The microsecond time base divides ticks by ticks_per_us.
// Status and distance_q4 show the outcome of the latest finished measurement.
// A result goes into the output register when that is free or being read,
// else into the skid register. Throughput: one word per cycle while in_ready
// is high; the whole state update, including the multiply for the distance,
// is one pass of logic into the state and output stage registers.
// A two-entry output stage (output register plus skid register) lets the
// block take one more word while a result waits; in_ready drops only while
// both entries are full. Reset clears the configuration to its defaults, the
// phase to idle, counters, last status and distance to zero, and empties the
// output stage. Configuration writes on cfg_we take effect the next cycle.
module ultrasonic_echo_ranger #(
	parameter int unsigned US_COUNT_WIDTH = uer_pkg::UER_US_COUNT_WIDTH,
	parameter int unsigned PRESCALE_WIDTH = uer_pkg::UER_PRESCALE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [uer_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [uer_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                start_req,
	input  logic                                echo_level,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                trig_level,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [1:0]                          status,
	output logic [uer_pkg::DIST_WIDTH-1:0]      distance_q4
);
	import uer_pkg::*;

	localparam int unsigned PW = PRESCALE_WIDTH;
	localparam int unsigned UW = US_COUNT_WIDTH;
	// Width for prescaler compares: holds ticks_per_us and 2^PW.
	localparam int unsigned EW = ((PW > 8) ? PW : 8) + 1;
	// Width for timeout compares.
	localparam int unsigned CW = (UW > 16) ? UW : 16;
	localparam int unsigned PRODW = DIST_CLAMP_WIDTH + DIST_RECIP_WIDTH;

	// Configuration registers.
	logic [7:0]  ticks_per_us_q;
	logic [15:0] start_to_q;
	logic [15:0] end_to_q;
	logic [8:0]  min_dist_q;
	logic [8:0]  max_dist_q;

	// Measurement state.
	logic [2:0]            phase_q, phase_d;
	logic [PW-1:0]         pc_q, pc_d;
	logic [UW-1:0]         mc_q, mc_d;
	logic [1:0]            last_status_q, last_status_d;
	logic [DIST_WIDTH-1:0] last_dist_q, last_dist_d;
	logic                  done_d;

	// Output stage.
	res_t out_q, skid_q, res_d;
	logic out_valid_q, skid_valid_q;

	logic accept, pop;

	// Prescaler and counter helpers.
	logic [EW-1:0] eff_ticks, pc_next_w;
	logic          strobe;
	logic [UW-1:0] mc_inc;
	logic          mc_full;

	// Distance conversion.
	logic                        mc_big;
	logic [DIST_CLAMP_WIDTH-1:0] mc_clamp;
	logic [PRODW-1:0]            prod;
	logic [DIST_Q_WIDTH-1:0]     dist_q;
	logic                        out_of_range;

	assign accept   = in_valid && in_ready;
	assign in_ready = !skid_valid_q;
	assign pop      = out_valid_q && out_ready;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_us_q <= RST_TICKS_PER_US;
			start_to_q     <= RST_START_TO;
			end_to_q       <= RST_END_TO;
			min_dist_q     <= RST_MIN_DIST;
			max_dist_q     <= RST_MAX_DIST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_US: ticks_per_us_q <= cfg_data[7:0];
				REG_START_TO:     start_to_q     <= cfg_data[15:0];
				REG_END_TO:       end_to_q       <= cfg_data[15:0];
				REG_MIN_DIST:     min_dist_q     <= cfg_data[8:0];
				REG_MAX_DIST:     max_dist_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Effective prescale: zero acts as one, values above 2^PW are clamped.
	always_comb begin
		eff_ticks = EW'(ticks_per_us_q);
		if (ticks_per_us_q == 8'd0) begin
			eff_ticks = EW'(1);
		end else if (EW'(ticks_per_us_q) > (EW'(1) << PW)) begin
			eff_ticks = EW'(1) << PW;
		end
	end

	assign pc_next_w = EW'(pc_q) + EW'(1);
	assign strobe    = (pc_next_w >= eff_ticks);
	assign mc_full   = (mc_q == {UW{1'b1}});
	assign mc_inc    = mc_full ? mc_q : (mc_q + UW'(1));

	// Distance in sixteenths of a centimeter by reciprocal multiply.
	assign mc_big   = (mc_q > UW'({DIST_CLAMP_WIDTH{1'b1}}));
	assign mc_clamp = mc_big ? {DIST_CLAMP_WIDTH{1'b1}} : mc_q[DIST_CLAMP_WIDTH-1:0];
	assign prod     = PRODW'(mc_clamp) * PRODW'(DIST_RECIP);
	assign dist_q   = prod[DIST_SHIFT +: DIST_Q_WIDTH];
	assign out_of_range = (dist_q < DIST_Q_WIDTH'({min_dist_q, 4'b0000}))
		|| (dist_q > DIST_Q_WIDTH'({max_dist_q, 4'b0000}));

	// Next state for one tick.
	always_comb begin
		phase_d       = phase_q;
		pc_d          = pc_q;
		mc_d          = mc_q;
		last_status_d = last_status_q;
		last_dist_d   = last_dist_q;
		done_d        = 1'b0;
		case (phase_q)
			PH_TLOW: begin
				if (strobe) begin
					pc_d = '0;
					mc_d = mc_inc;
					if (mc_inc >= UW'(TRIG_LOW_US)) begin
						phase_d = PH_THIGH;
						mc_d    = '0;
					end
				end else begin
					pc_d = pc_next_w[PW-1:0];
				end
			end
			PH_THIGH: begin
				if (strobe) begin
					pc_d = '0;
					mc_d = mc_inc;
					if (mc_inc >= UW'(TRIG_HIGH_US)) begin
						phase_d = PH_WAIT;
						mc_d    = '0;
					end
				end else begin
					pc_d = pc_next_w[PW-1:0];
				end
			end
			PH_WAIT: begin
				if (echo_level) begin
					phase_d = PH_MEAS;
					pc_d    = '0;
					mc_d    = '0;
				end else if (strobe) begin
					pc_d = '0;
					if (CW'(mc_q) >= CW'(start_to_q)) begin
						phase_d       = PH_IDLE;
						mc_d          = '0;
						last_status_d = ST_NOECHO;
						last_dist_d   = '0;
						done_d        = 1'b1;
					end else begin
						mc_d = mc_inc;
					end
				end else begin
					pc_d = pc_next_w[PW-1:0];
				end
			end
			PH_MEAS: begin
				if (!echo_level) begin
					phase_d = PH_IDLE;
					pc_d    = '0;
					mc_d    = '0;
					done_d  = 1'b1;
					if (out_of_range) begin
						last_status_d = ST_RANGE;
						last_dist_d   = '0;
					end else begin
						last_status_d = ST_OK;
						last_dist_d   = dist_q[DIST_WIDTH-1:0];
					end
				end else if (strobe) begin
					pc_d = '0;
					if (CW'(mc_q) >= CW'(end_to_q)) begin
						phase_d       = PH_IDLE;
						mc_d          = '0;
						last_status_d = ST_LONG;
						last_dist_d   = '0;
						done_d        = 1'b1;
					end else begin
						mc_d = mc_inc;
					end
				end else begin
					pc_d = pc_next_w[PW-1:0];
				end
			end
			default: begin
				// Idle, and any unused code behaves as idle.
				phase_d = PH_IDLE;
				if (start_req) begin
					phase_d = PH_TLOW;
					pc_d    = '0;
					mc_d    = '0;
				end
			end
		endcase
	end

	// Result word for this tick, taken after the update.
	always_comb begin
		res_d.trig_level  = (phase_d == PH_THIGH);
		res_d.busy_res    = (phase_d != PH_IDLE);
		res_d.done_res    = done_d;
		res_d.status      = last_status_d;
		res_d.distance_q4 = last_dist_d;
	end

	// State registers advance only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			pc_q          <= '0;
			mc_q          <= '0;
			last_status_q <= ST_OK;
			last_dist_q   <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			pc_q          <= pc_d;
			mc_q          <= mc_d;
			last_status_q <= last_status_d;
			last_dist_q   <= last_dist_d;
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_d;
			end
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign trig_level  = out_q.trig_level;
	assign busy_res    = out_q.busy_res;
	assign done_res    = out_q.done_res;
	assign status      = out_q.status;
	assign distance_q4 = out_q.distance_q4;

	// A finished measurement always reports idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// The trigger is only driven high during a measurement.
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trig_level |-> busy_res)
		else $error("trigger high outside a measurement");

	// Failed measurements carry a zero distance.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (distance_q4 == '0))
		else $error("nonzero distance with failure status");

	// The skid entry is only filled behind a full output register.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// Phase moves only when a word is accepted.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q))
		else $error("phase changed without an accepted word");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_echo_ranger: ticks are streamed through the
// valid/ready channels and every result word is compared against an in-bench predictor.
// Depends on uer_pkg and the ultrasonic_echo_ranger design.
module testbench;
	import uer_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int BLOCK_WORDS   = 30;
	localparam int MAX_REPORTS   = 10;
	localparam int unsigned US_MAX = (1 << UER_US_COUNT_WIDTH) - 1;
	// Distance in 1/16 cm is us * 16 / 58, reduced to us * 8 / 29.
	localparam int unsigned DIST_NUM = 8;
	localparam int unsigned DIST_DEN = 29;
	localparam int unsigned Q4_PER_CM = 16;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_UNUSED = REG_MAX_DIST + 1'b1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LAST_UNUSED  = '1;

	typedef struct packed {
		logic start;
		logic echo;
	} tick_t;

	// Design ports.
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       start_req = 1'b0;
	logic                       echo_level = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       trig_level;
	logic                       busy_res;
	logic                       done_res;
	logic [1:0]                 status;
	logic [DIST_WIDTH-1:0]      distance_q4;

	// Stimulus and checking bookkeeping.
	tick_t tick_q[$];
	res_t  ranger_out_q[$];
	int    n_queued = 0;
	int    n_checked = 0;
	int    n_fail = 0;
	logic  in_taken = 1'b0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    hold_req = 0;
	int    hold_ack = 0;
	int    hold_left = 0;
	int    idle_cycles = 0;

	// Predictor copy of the configuration and of the ranging state.
	logic [7:0]            cfg_tpu = RST_TICKS_PER_US;
	logic [15:0]           cfg_sto = RST_START_TO;
	logic [15:0]           cfg_eto = RST_END_TO;
	logic [8:0]            cfg_min = RST_MIN_DIST;
	logic [8:0]            cfg_max = RST_MAX_DIST;
	logic [2:0]            rng_phase = PH_IDLE;
	int unsigned           pre_cnt = 0;
	int unsigned           us_cnt = 0;
	logic [DIST_WIDTH-1:0] last_dist = '0;
	logic [1:0]            last_stat = ST_OK;

	ultrasonic_echo_ranger uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_req  (start_req),
		.echo_level (echo_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.trig_level (trig_level),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.status     (status),
		.distance_q4(distance_q4)
	);

	always #2 clk = ~clk;

	// A prescale of zero counts as one; an 8-bit register can never exceed 2^8.
	function automatic int unsigned us_ticks();
		return (cfg_tpu == 0) ? 1 : int'(cfg_tpu);
	endfunction

	// Advances the prescaler by one tick and reports a microsecond strobe.
	function automatic bit us_strobe();
		if (pre_cnt + 1 >= us_ticks()) begin
			pre_cnt = 0;
			return 1'b1;
		end
		pre_cnt++;
		return 1'b0;
	endfunction

	function automatic void us_bump();
		if (us_cnt < US_MAX) us_cnt++;
	endfunction

	function automatic void enter_phase(input logic [2:0] ph);
		rng_phase = ph;
		pre_cnt = 0;
		us_cnt = 0;
	endfunction

	function automatic void finish_meas(input logic [1:0] st,
			input logic [DIST_WIDTH-1:0] dist_val);
		last_stat = st;
		last_dist = dist_val;
		enter_phase(PH_IDLE);
	endfunction

	// One clock tick of the ranger; returns the result word seen after the update.
	task automatic advance_ranger(input logic start, input logic echo, output res_t r);
		int unsigned q;
		logic done;
		done = 1'b0;
		case (rng_phase)
			PH_TLOW: begin
				if (us_strobe()) begin
					us_bump();
					if (us_cnt >= TRIG_LOW_US) enter_phase(PH_THIGH);
				end
			end
			PH_THIGH: begin
				if (us_strobe()) begin
					us_bump();
					if (us_cnt >= TRIG_HIGH_US) enter_phase(PH_WAIT);
				end
			end
			PH_WAIT: begin
				if (echo) begin
					enter_phase(PH_MEAS);
				end else if (us_strobe()) begin
					if (us_cnt >= cfg_sto) begin
						finish_meas(ST_NOECHO, '0);
						done = 1'b1;
					end else begin
						us_bump();
					end
				end
			end
			PH_MEAS: begin
				if (!echo) begin
					q = (us_cnt * DIST_NUM) / DIST_DEN;
					if (q < int'(cfg_min) * Q4_PER_CM || q > int'(cfg_max) * Q4_PER_CM) begin
						finish_meas(ST_RANGE, '0);
					end else begin
						finish_meas(ST_OK, q[DIST_WIDTH-1:0]);
					end
					done = 1'b1;
				end else if (us_strobe()) begin
					if (us_cnt >= cfg_eto) begin
						finish_meas(ST_LONG, '0);
						done = 1'b1;
					end else begin
						us_bump();
					end
				end
			end
			default: begin
				// Stray phase codes fall back to idle; a start is only taken here.
				rng_phase = PH_IDLE;
				if (start) enter_phase(PH_TLOW);
			end
		endcase
		r.trig_level  = (rng_phase == PH_THIGH);
		r.busy_res    = (rng_phase != PH_IDLE);
		r.done_res    = done;
		r.status      = last_stat;
		r.distance_q4 = last_dist;
	endtask

	task automatic push_tick(input logic start, input logic echo);
		tick_t w;
		w.start = start;
		w.echo = echo;
		tick_q.push_back(w);
		n_queued++;
	endtask

	// Queues one measurement: idle lead-in, start, trigger time with optional
	// starts while busy, a silent wait, an echo pulse and a quiet tail.
	task automatic queue_measurement(input int lead, input int wait_ticks, input int echo_ticks,
			input bit busy_starts);
		repeat (lead) push_tick(1'b0, 1'($urandom));
		push_tick(1'b1, 1'($urandom));
		repeat ((TRIG_LOW_US + TRIG_HIGH_US) * us_ticks())
			push_tick(busy_starts & 1'($urandom), 1'($urandom));
		repeat (wait_ticks) push_tick(1'b0, 1'b0);
		repeat (echo_ticks) push_tick(1'b0, 1'b1);
		repeat (3) push_tick(1'b0, 1'b0);
	endtask

	// Register write; the predictor copy is updated with the masked value.
	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TICKS_PER_US: cfg_tpu = data[7:0];
			REG_START_TO:     cfg_sto = data;
			REG_END_TO:       cfg_eto = data;
			REG_MIN_DIST:     cfg_min = data[8:0];
			REG_MAX_DIST:     cfg_max = data[8:0];
			default: ;
		endcase
	endtask

	task automatic write_unused_reg();
		write_reg(CFG_INDEX_WIDTH'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
			CFG_DATA_WIDTH'($urandom));
	endtask

	// Waits until every queued word has come back, then lets the block settle.
	task automatic drain();
		wait (n_checked == n_queued);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: a new word is offered only once the current one is taken.
	always @(negedge clk) begin
		tick_t w;
		if (!in_valid || in_taken) begin
			if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				w = tick_q.pop_front();
				in_valid <= 1'b1;
				start_req <= w.start;
				echo_level <= w.echo;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted here once requested.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_left <= HOLD_CYCLES;
			hold_ack <= hold_req;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: predicts on every accepted input word, checks every result word.
	always @(posedge clk) begin
		res_t due;
		res_t seen;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			advance_ranger(start_req, echo_level, due);
			ranger_out_q.push_back(due);
		end
		if (out_valid && out_ready) begin
			seen = {trig_level, busy_res, done_res, status, distance_q4};
			n_checked++;
			if (ranger_out_q.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("word %0d: result with nothing expected", n_checked);
			end else begin
				due = ranger_out_q.pop_front();
				if (seen !== due) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display({"word %0d mismatch (exp/got): trig %b/%b busy %b/%b ",
							"done %b/%b status %0d/%0d dist %0d/%0d"}, n_checked,
							due.trig_level, seen.trig_level, due.busy_res, seen.busy_res,
							due.done_res, seen.done_res, due.status, seen.status,
							due.distance_q4, seen.distance_q4);
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("ultrasonic_echo_ranger regression: fail");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		int send_pcts[4];
		int recv_pcts[4];
		int base;
		int wait_ticks;
		int echo_ticks;
		send_pcts = '{0, 80, 0, 28};
		recv_pcts = '{0, 0, 80, 28};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: an echo well inside the default range.
		queue_measurement(2, 3, 200, 1'b0);
		drain();

		// Low extremes: zero prescale, zero timeouts, widest range; junk in upper bits.
		write_reg(REG_TICKS_PER_US, {8'($urandom), 8'd0});
		write_reg(REG_START_TO, 16'd0);
		write_reg(REG_END_TO, 16'd0);
		write_reg(REG_MIN_DIST, {7'($urandom), 9'd0});
		write_reg(REG_MAX_DIST, {7'($urandom), 9'd511});
		write_unused_reg();
		queue_measurement(1, 4, 0, 1'b1);   // no echo, fails on first strobe
		queue_measurement(0, 0, 1, 1'b0);   // echo at once for one tick, distance zero
		queue_measurement(1, 0, 5, 1'b1);   // echo outlasts a zero end timeout
		drain();

		// High extremes: a slow prescale, longest timeouts, min above max.
		write_reg(REG_TICKS_PER_US, 16'd4);
		write_reg(REG_START_TO, 16'hFFFF);
		write_reg(REG_END_TO, 16'hFFFF);
		write_reg(REG_MIN_DIST, 16'd511);
		write_reg(REG_MAX_DIST, 16'd0);
		queue_measurement(0, 40, 2 * 4, 1'b0);
		drain();

		// Range edges around one centimeter and a start timeout.
		write_reg(REG_TICKS_PER_US, 16'd1);
		write_reg(REG_START_TO, 16'd4);
		write_reg(REG_END_TO, 16'd100);
		write_reg(REG_MIN_DIST, 16'd1);
		write_reg(REG_MAX_DIST, 16'd1);
		queue_measurement(0, 2, 59, 1'b0);
		queue_measurement(0, 2, 58, 1'b0);
		queue_measurement(0, 2, 63, 1'b0);
		queue_measurement(0, 20, 0, 1'b0);
		drain();

		// Random part: mostly well-formed measurements, some noise, per idling mode.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pcts[ph];
			recv_stall_pct = recv_pcts[ph];
			for (int blk = 0; blk < 2; blk++) begin
				write_reg(REG_TICKS_PER_US, {8'($urandom),
					($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 3))});
				write_reg(REG_START_TO, 16'($urandom_range(0, 15)));
				write_reg(REG_END_TO, 16'($urandom_range(0, 30)));
				write_reg(REG_MIN_DIST, {7'($urandom), 9'($urandom_range(0, 2))});
				write_reg(REG_MAX_DIST, {7'($urandom), 9'($urandom_range(0, 3))});
				if ($urandom_range(1) == 0) write_unused_reg();
				base = n_queued;
				while (n_queued - base < BLOCK_WORDS) begin
					if ($urandom_range(99) < 15) begin
						repeat ($urandom_range(4, 24)) push_tick(1'($urandom), 1'($urandom));
					end else begin
						wait_ticks = $urandom_range(0, cfg_sto + 3) * us_ticks()
							+ $urandom_range(0, us_ticks() - 1);
						echo_ticks = $urandom_range(0, (cfg_eto + 3) * us_ticks());
						queue_measurement($urandom_range(0, 3), wait_ticks, echo_ticks,
							1'($urandom));
					end
				end
				// With the input queue full, hold the receiver off so the block backs up.
				if (ph == 0 && blk == 0) hold_req++;
				drain();
			end
		end

		if (n_fail == 0 && ranger_out_q.size() == 0) begin
			$display("ultrasonic_echo_ranger regression: pass");
		end else begin
			$display("ultrasonic_echo_ranger regression: fail");
		end
		$finish;
	end

endmodule
